// ===== design/ctw_pkg.sv =====
package ctw_pkg;

    // Wheel and client table sizes.
    localparam int WHEEL_SLOTS  = 64;
    localparam int CLIENT_SLOTS = 64;

    // Width of a wheel slot number and of a client table index.
    localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int CIDX_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;

    // Opcodes.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_ABSENT    = 2'd2;
    localparam logic [1:0] ST_PRESENT   = 2'd3;

    // Request beat.
    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] client_index;
        logic [7:0] timeout;
        logic [7:0] tick_count;
    } req_t;

    // Response beat.
    typedef struct packed {
        logic [1:0] status;
        logic       present;
        logic       expired_valid;
        logic [5:0] expired_client;
        logic       last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the request beat
        logic rd_en;    // read the slot of the client under the scan index
        logic step;     // evaluate the scanned client and advance the scan
        logic flush;    // emit the final beat of a tick
    } ctw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // response register can take a beat this cycle
        logic start_run;  // request is a tick with a nonzero count
        logic hit;        // scanned client expires now
        logic has_pend;   // an expired client waits to be emitted
        logic scan_end;   // scanned client is the last of the last tick
    } ctw_sts_t;

endpackage

// ===== design/ctw_ram.sv =====
module ctw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ctw_ctrl.sv =====
module ctw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ctw_pkg::ctw_sts_t sts,
    output ctw_pkg::ctw_cmd_t cmd
);

    import ctw_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       stall;

    // A hit must push out the held client, which needs a free response register.
    assign stall = sts.hit && sts.has_pend && !sts.out_free;

    assign req_ready = (state_reg == S_IDLE) && sts.out_free;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = req_valid && sts.out_free;
                if (cmd.accept && sts.start_run)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stall)
                begin
                    cmd.step   = 1'b1;
                    state_next = sts.scan_end ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ctw_dp.sv =====
module ctw_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ctw_pkg::req_t     req,
    output ctw_pkg::rsp_t     rsp,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  ctw_pkg::ctw_cmd_t cmd,
    output ctw_pkg::ctw_sts_t sts
);

    import ctw_pkg::*;

    logic [CLIENT_SLOTS-1:0] valid_reg;
    logic [CLIENT_SLOTS-1:0] valid_next;
    logic [SLOT_W-1:0]       cur_reg;
    logic [SLOT_W-1:0]       cur_next;
    logic [CIDX_W-1:0]       cnt_reg;
    logic [CIDX_W-1:0]       cnt_next;
    logic [7:0]              ticks_reg;
    logic [7:0]              ticks_next;
    logic                    pend_vld_reg;
    logic                    pend_vld_next;
    logic [CIDX_W-1:0]       pend_reg;
    logic [CIDX_W-1:0]       pend_next;
    logic                    out_vld_reg;
    logic                    out_vld_next;
    rsp_t                    out_reg;
    rsp_t                    out_next;

    logic [CIDX_W-1:0]       ci;
    logic                    in_range;
    logic                    here;
    logic                    to_ok;
    logic [SLOT_W:0]         slot_sum;
    logic [SLOT_W-1:0]       new_slot;
    logic                    add_ok;
    logic [SLOT_W-1:0]       ram_rdata;
    logic                    hit;
    logic                    last_client;
    logic [SLOT_W-1:0]       cur_inc;
    logic                    load;

    // Request decode: range check, presence and target slot for an add.
    assign ci       = req.client_index[CIDX_W-1:0];
    assign in_range = {1'b0, req.client_index} < 7'(CLIENT_SLOTS);
    assign here     = in_range && valid_reg[ci];
    assign to_ok    = {1'b0, req.timeout} < 9'(WHEEL_SLOTS);
    assign slot_sum = {1'b0, cur_reg} + {1'b0, req.timeout[SLOT_W-1:0]};
    assign new_slot = (slot_sum >= (SLOT_W+1)'(WHEEL_SLOTS))
                    ? SLOT_W'(slot_sum - (SLOT_W+1)'(WHEEL_SLOTS))
                    : slot_sum[SLOT_W-1:0];
    assign add_ok   = cmd.accept && (req.opcode == OP_ADD) && to_ok && in_range && !here;

    // Client slot table.
    ctw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CLIENT_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (add_ok),
        .waddr (ci),
        .wdata (new_slot),
        .re    (cmd.rd_en),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    // Scan compare and wrap points.
    assign hit         = valid_reg[cnt_reg] && (ram_rdata == cur_reg);
    assign last_client = cnt_reg == CIDX_W'(CLIENT_SLOTS - 1);
    assign cur_inc     = (cur_reg == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : cur_reg + 1'b1;

    assign sts.out_free  = !out_vld_reg || rsp_ready;
    assign sts.start_run = (req.opcode == OP_TICK) && (req.tick_count != 8'd0);
    assign sts.hit       = hit;
    assign sts.has_pend  = pend_vld_reg;
    assign sts.scan_end  = last_client && (ticks_reg == 8'd1);

    // Next state of the table, the scan and the response register.
    always_comb
    begin
        valid_next    = valid_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        ticks_next    = ticks_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        load          = 1'b0;

        if (cmd.accept)
        begin
            out_next      = '0;
            out_next.last = 1'b1;
            unique case (req.opcode)
                OP_ADD:
                begin
                    load = 1'b1;
                    if (!to_ok)
                    begin
                        out_next.status = ST_TOO_LARGE;
                    end
                    else if (!in_range)
                    begin
                        out_next.status = ST_ABSENT;
                    end
                    else if (here)
                    begin
                        out_next.status = ST_PRESENT;
                    end
                    else
                    begin
                        out_next.status = ST_OK;
                        valid_next[ci]  = 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    load             = 1'b1;
                    out_next.present = here;
                end
                OP_REMOVE:
                begin
                    load = 1'b1;
                    if (here)
                    begin
                        valid_next[ci] = 1'b0;
                    end
                    else
                    begin
                        out_next.status = ST_ABSENT;
                    end
                end
                OP_TICK:
                begin
                    // A zero count gives the empty final beat at once.
                    load          = !sts.start_run;
                    cnt_next      = '0;
                    ticks_next    = req.tick_count;
                    pend_vld_next = 1'b0;
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end

        if (cmd.step)
        begin
            if (hit)
            begin
                valid_next[cnt_reg] = 1'b0;
                pend_vld_next       = 1'b1;
                pend_next           = cnt_reg;
                // The held client is not the final one, so it goes out now.
                if (pend_vld_reg)
                begin
                    load                    = 1'b1;
                    out_next                = '0;
                    out_next.expired_valid  = 1'b1;
                    out_next.expired_client = 6'(pend_reg);
                end
            end
            if (last_client)
            begin
                cnt_next   = '0;
                cur_next   = cur_inc;
                ticks_next = ticks_reg - 8'd1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (cmd.flush)
        begin
            load                    = 1'b1;
            out_next                = '0;
            out_next.last           = 1'b1;
            out_next.expired_valid  = pend_vld_reg;
            out_next.expired_client = pend_vld_reg ? 6'(pend_reg) : 6'd0;
            pend_vld_next           = 1'b0;
        end

        if (load)
        begin
            out_vld_next = 1'b1;
        end
        else
        begin
            out_vld_next = out_vld_reg && !rsp_ready;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            cur_reg      <= '0;
            cnt_reg      <= '0;
            ticks_reg    <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            cur_reg      <= cur_next;
            cnt_reg      <= cnt_next;
            ticks_reg    <= ticks_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign rsp       = out_reg;
    assign rsp_valid = out_vld_reg;

endmodule

// ===== design/client_timeout_wheel.sv =====
// Add, query and remove: the response beat is valid in the cycle after acceptance;
// a new request is taken every cycle while the response register drains.
// Tick: each tick scans the client slot table, per client a RAM read then a compare;
// after the last tick a flush emits the final beat; response stalls can hold the scan.
// Reset (rst_n, asynchronous, active low) clears the slot pointer and all presence bits;
// the client slot table needs no clearing.
module client_timeout_wheel (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ctw_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ctw_pkg::rsp_t rsp
);

    import ctw_pkg::*;

    ctw_cmd_t cmd;
    ctw_sts_t sts;

    // Sequencer for request handling and the tick scan.
    ctw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Client table, slot pointer and response register.
    ctw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== sim/ctw_checker.sv =====
module ctw_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  ctw_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  ctw_pkg::rsp_t rsp,
    output int            errors,
    output int            pending,
    output int            beats,
    output int            expirations
);
    timeunit 1ns;
    timeprecision 1ps;

    import ctw_pkg::*;

    // Shadow copy of the wheel: presence bit and filed slot per client.
    logic              live    [CLIENT_SLOTS];
    logic [SLOT_W-1:0] slot_of [CLIENT_SLOTS];
    logic [SLOT_W-1:0] now_slot;

    // Response beats the block still owes, oldest first.
    rsp_t owed_rsp [$];
    rsp_t want;

    // Apply one request to the shadow wheel and queue the beats it must produce.
    function automatic void wheel_step(req_t r);
        rsp_t beat;
        rsp_t fired [$];
        int   ci;
        int   landing;
        beat      = '0;
        beat.last = 1'b1;
        ci        = int'(r.client_index);
        case (r.opcode)
            OP_ADD:
            begin
                if (int'(r.timeout) >= WHEEL_SLOTS)
                    beat.status = ST_TOO_LARGE;
                else if (ci >= CLIENT_SLOTS)
                    beat.status = ST_ABSENT;
                else if (live[ci])
                    beat.status = ST_PRESENT;
                else
                begin
                    landing     = (int'(now_slot) + int'(r.timeout)) % WHEEL_SLOTS;
                    live[ci]    = 1'b1;
                    slot_of[ci] = landing[SLOT_W-1:0];
                    beat.status = ST_OK;
                end
                owed_rsp.push_back(beat);
            end
            OP_QUERY:
            begin
                beat.status  = ST_OK;
                beat.present = (ci < CLIENT_SLOTS) && live[ci];
                owed_rsp.push_back(beat);
            end
            OP_REMOVE:
            begin
                if ((ci < CLIENT_SLOTS) && live[ci])
                begin
                    live[ci]    = 1'b0;
                    beat.status = ST_OK;
                end
                else
                    beat.status = ST_ABSENT;
                owed_rsp.push_back(beat);
            end
            default:
            begin
                // Each tick expires the current slot in ascending client order.
                for (int t = 0; t < int'(r.tick_count); t++)
                begin
                    for (int c = 0; c < CLIENT_SLOTS; c++)
                    begin
                        if (live[c] && slot_of[c] == now_slot)
                        begin
                            live[c] = 1'b0;
                            if (fired.size() < 64)
                            begin
                                beat                = '0;
                                beat.expired_valid  = 1'b1;
                                beat.expired_client = c[5:0];
                                fired.push_back(beat);
                            end
                        end
                    end
                    landing  = (int'(now_slot) + 1) % WHEEL_SLOTS;
                    now_slot = landing[SLOT_W-1:0];
                end
                // A tick that expires nobody still closes with one empty beat.
                if (fired.size() == 0)
                begin
                    beat      = '0;
                    beat.last = 1'b1;
                    owed_rsp.push_back(beat);
                end
                else
                begin
                    fired[fired.size() - 1].last = 1'b1;
                    foreach (fired[i])
                        owed_rsp.push_back(fired[i]);
                end
            end
        endcase
    endfunction

    // Watch both channels at each edge: compare responses first, then predict.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_slot = '0;
            foreach (live[i])
                live[i] = 1'b0;
            owed_rsp.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                beats++;
                if (rsp.expired_valid)
                    expirations++;
                if (owed_rsp.size() == 0)
                begin
                    $error("response beat with nothing owed: status %0d client %0d last %0d",
                           rsp.status, rsp.expired_client, rsp.last);
                    errors++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.present !== want.present)
                    begin
                        $error("present: expected %0d, actual %0d", want.present, rsp.present);
                        errors++;
                    end
                    if (rsp.expired_valid !== want.expired_valid)
                    begin
                        $error("expired_valid: expected %0d, actual %0d",
                               want.expired_valid, rsp.expired_valid);
                        errors++;
                    end
                    if (rsp.expired_client !== want.expired_client)
                    begin
                        $error("expired_client: expected %0d, actual %0d",
                               want.expired_client, rsp.expired_client);
                        errors++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, rsp.last);
                        errors++;
                    end
                end
            end
            if (req_valid && req_ready)
                wheel_step(req);
            pending <= owed_rsp.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctw_pkg::*;

    localparam int ITEMS       = 450;
    localparam int IDLE_LIMIT  = 150000;
    localparam int HOLD_CYCLES = 400;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int errors;
    int pending;
    int beats;
    int expirations;

    // Stimulus bookkeeping.
    int n_items    = 0;
    int n_ticks    = 0;
    int burst_left = 0;
    bit steady     = 1'b0;
    int hold_seq   = 0;
    int idle_count = 0;

    client_timeout_wheel u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ctw_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .errors      (errors),
        .pending     (pending),
        .beats       (beats),
        .expirations (expirations)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: switches between stall patterns, and honors a long hold-off on request.
    always @(posedge clk)
    begin
        logic     go;
        static int hold_seen = 0;
        static int hold_left = 0;
        static int rx_mode   = 0;
        static int rx_left   = 0;
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 150);
        end
        rx_left--;
        case (rx_mode)
            0:       go = 1'b1;
            1:       go = 1'($urandom_range(0, 1));
            2:       go = ($urandom_range(0, 3) == 0);
            default: go = rx_left[1];
        endcase
        if (hold_left > 0)
        begin
            hold_left--;
            go = 1'b0;
        end
        rsp_ready <= go;
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= IDLE_LIMIT)
        begin
            $error("no beat moved for %0d cycles, %0d responses still owed",
                   IDLE_LIMIT, pending);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic req_t make_req(logic [1:0] op, int ci, int to, int tc);
        req_t r;
        r.opcode       = op;
        r.client_index = ci[5:0];
        r.timeout      = to[7:0];
        r.tick_count   = tc[7:0];
        return r;
    endfunction

    // Offer one request beat; bursts end in random gaps unless the sender is steady.
    task automatic issue(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && !steady)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        n_items++;
        if (r.opcode == OP_TICK)
            n_ticks++;
    endtask

    // Stop offering and wait until every owed response has come back.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int  pick;
        int  ci;
        int  to;
        int  tc;
        int  k;
        bit  held;
        bit  flooded;
        bit  paused;
        held    = 1'b0;
        flooded = 1'b0;
        paused  = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: errors, duplicates, wrap of the slot pointer, multi-client slots.
        issue(make_req(OP_ADD, 0, 0, 0));
        issue(make_req(OP_ADD, 63, 63, 0));
        issue(make_req(OP_ADD, 5, 64, 0));
        issue(make_req(OP_ADD, 9, 255, 0));
        issue(make_req(OP_ADD, 0, 3, 0));
        issue(make_req(OP_QUERY, 0, 0, 0));
        issue(make_req(OP_QUERY, 7, 0, 0));
        issue(make_req(OP_REMOVE, 63, 0, 0));
        issue(make_req(OP_REMOVE, 63, 0, 0));
        issue(make_req(OP_TICK, 0, 0, 0));
        issue(make_req(OP_TICK, 0, 0, 1));
        issue(make_req(OP_ADD, 40, 1, 0));
        issue(make_req(OP_ADD, 3, 1, 0));
        issue(make_req(OP_ADD, 10, 1, 0));
        issue(make_req(OP_ADD, 63, 0, 0));
        issue(make_req(OP_ADD, 21, 63, 0));
        issue(make_req(OP_TICK, 0, 0, 2));
        issue(make_req(OP_ADD, 1, 2, 0));
        issue(make_req(OP_QUERY, 1, 0, 0));
        issue(make_req(OP_TICK, 0, 0, 255));
        issue(make_req(OP_REMOVE, 21, 0, 0));
        issue(make_req(OP_ADD, 21, 63, 0));

        // Random: add/query/remove sessions on one client for half the picks, plus ticks and noise.
        while (n_items < ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (!held && n_items >= 150)
            begin
                // Receiver holds off while the sender keeps pushing, filling the block.
                hold_seq <= hold_seq + 1;
                steady = 1'b1;
                repeat (24)
                    issue(make_req(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 255),
                                   $urandom_range(0, 255)));
                steady = 1'b0;
                held   = 1'b1;
            end
            else if (!flooded && n_items >= 230)
            begin
                // Fill every client so one tick run expires all clients that these adds filed.
                for (int c = 0; c < CLIENT_SLOTS; c++)
                    issue(make_req(OP_ADD, c, $urandom_range(0, 3), $urandom_range(0, 255)));
                issue(make_req(OP_TICK, $urandom_range(0, 63), $urandom_range(0, 255), 6));
                flooded = 1'b1;
            end
            else if ((!paused && n_items >= 320) || pick >= 98)
            begin
                settle();
                paused = 1'b1;
            end
            else if (pick < 50)
            begin
                ci  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 63);
                k   = $urandom_range(0, 99);
                to  = (k < 60) ? $urandom_range(0, 12) :
                      (k < 90) ? $urandom_range(0, 63) : $urandom_range(64, 255);
                issue(make_req(OP_ADD, ci, to, $urandom_range(0, 255)));
                repeat ($urandom_range(0, 3))
                    issue(make_req(($urandom_range(0, 1) == 0) ? OP_QUERY : OP_REMOVE, ci,
                                   $urandom_range(0, 255), $urandom_range(0, 255)));
            end
            else if (pick < 80)
            begin
                req_t r;
                r = make_req(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                             $urandom_range(0, 255), $urandom_range(0, 255));
                if (r.opcode == OP_TICK)
                    r.tick_count = 8'($urandom_range(0, 7));
                issue(r);
            end
            else
            begin
                k  = $urandom_range(0, 99);
                tc = (k < 10) ? 0 : (k < 75) ? $urandom_range(1, 4) :
                     (k < 95) ? $urandom_range(5, 40) : $urandom_range(41, 100);
                issue(make_req(OP_TICK, $urandom_range(0, 63), $urandom_range(0, 255), tc));
            end
        end

        // Let the last responses drain, then watch a little longer for strays.
        settle();
        repeat (30) @(posedge clk);

        $display("Run drove %0d requests, %0d of them ticks, through random stalls on both sides.",
                 n_items, n_ticks);
        $display("Checked %0d response beats, %0d of them client expirations.",
                 beats, expirations);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
